@@ sv/adc_pkg.sv @@
package adc_pkg;

  // Fixed point: 8 fraction bits, one pixel is 256.
  localparam int FracBits  = 8;
  localparam int RegW      = 21;
  localparam int PixW      = 12;
  localparam int AbsW      = 21;
  localparam int SqW       = 2 * AbsW;
  localparam int RadW      = 44;
  localparam int RootW     = 22;
  localparam int RemW      = 26;
  localparam int CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_THICKNESS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RING_MODE = 3'd4;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic             valid;
    logic             oob;
    logic [RadW-1:0]  x;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } adc_cell_t;

endpackage

@@ sv/adc_front.sv @@
module adc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      in_oob,
  input  logic [adc_pkg::PixW-1:0]  pixel_x,
  input  logic [adc_pkg::PixW-1:0]  pixel_y,
  input  logic [adc_pkg::RegW-1:0]  center_x,
  input  logic [adc_pkg::RegW-1:0]  center_y,
  output adc_pkg::adc_cell_t        cell_o
);
  import adc_pkg::*;

  logic signed [AbsW:0] dx, dy;
  logic [AbsW-1:0] adx_r, ady_r;
  logic [SqW-1:0]  sqx_r, sqy_r;
  logic [2:0]      valid_r, oob_r;
  logic [RadW-1:0] sum_r;

  always_comb begin
    dx = $signed({1'b0, pixel_x, 8'd0}) - $signed({center_x[RegW-1], center_x});
    dy = $signed({1'b0, pixel_y, 8'd0}) - $signed({center_y[RegW-1], center_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oob_r <= {oob_r[1:0], in_oob};
      adx_r <= dx[AbsW] ? AbsW'(-dx) : AbsW'(dx);
      ady_r <= dy[AbsW] ? AbsW'(-dy) : AbsW'(dy);
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
      sum_r <= RadW'(sqx_r) + RadW'(sqy_r);
    end
  end

  assign cell_o.valid = valid_r[2];
  assign cell_o.oob   = oob_r[2];
  assign cell_o.x     = sum_r;
  assign cell_o.rem   = '0;
  assign cell_o.root  = '0;

endmodule

@@ sv/adc_cell.sv @@
module adc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  adc_pkg::adc_cell_t cell_i,
  output adc_pkg::adc_cell_t cell_o
);
  import adc_pkg::*;

  logic [RemW-1:0] rem_sh, trial;
  adc_cell_t       cell_r, cell_nxt;

  // One result bit per cell: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem_sh         = {cell_i.rem[RemW-3:0], cell_i.x[RadW-1 -: 2]};
    trial          = {{(RemW-RootW-2){1'b0}}, cell_i.root, 2'b01};
    cell_nxt       = cell_i;
    cell_nxt.x     = {cell_i.x[RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = rem_sh - trial;
      cell_nxt.root = {cell_i.root[RootW-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh;
      cell_nxt.root = {cell_i.root[RootW-2:0], 1'b0};
    end
  end

  // Only the valid bit matters in reset; the data fields simply hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

@@ sv/adc_shade.sv @@
module adc_shade (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  adc_pkg::adc_cell_t        cell_i,
  input  logic [adc_pkg::RegW-1:0]  radius,
  input  logic [adc_pkg::RegW-1:0]  thickness,
  input  logic                      ring_mode,
  output logic                      valid_o,
  output logic                      lit_o,
  output logic [7:0]                alpha_o
);
  import adc_pkg::*;

  localparam int SW = 25;
  localparam logic signed [SW-1:0] One = SW'(1 << FracBits);

  logic signed [SW-1:0] r_eff, inner, d, dr_o, dr_i, rad_m;
  logic [16:0]          prod;
  logic [8:0]           frac;
  logic                 lit_nxt, valid_r, lit_r;
  logic [7:0]           alpha_nxt, alpha_r;

  always_comb begin
    rad_m  = $signed({{(SW-RegW){1'b0}}, radius}) - One;
    r_eff  = (rad_m < One) ? One : rad_m;
    inner  = r_eff - $signed({{(SW-RegW){1'b0}}, thickness});
    d      = $signed({{(SW-RootW){1'b0}}, cell_i.root});
    dr_o   = d - r_eff;
    dr_i   = d - inner;
    lit_nxt   = 1'b0;
    alpha_nxt = 8'd0;
    frac      = 9'd0;
    if (d < r_eff && (!ring_mode || d > inner)) begin
      lit_nxt   = 1'b1;
      alpha_nxt = 8'hFF;
    end
    if (dr_o >= 0 && dr_o < One) begin
      frac    = 9'(One - dr_o);
      lit_nxt = 1'b1;
    end
    if (ring_mode && dr_i >= 0 && dr_i < One) begin
      frac    = 9'(dr_i);
      lit_nxt = 1'b1;
    end
    prod = {frac, 8'd0} - {8'd0, frac};
    if ((dr_o >= 0 && dr_o < One) || (ring_mode && dr_i >= 0 && dr_i < One)) begin
      alpha_nxt = prod[15:8];
    end
    if (cell_i.oob) begin
      lit_nxt   = 1'b0;
      alpha_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= cell_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lit_r   <= lit_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lit_o   = lit_r;
  assign alpha_o = alpha_r;

endmodule

@@ sv/antialiased_disc_ring_coverage.sv @@
// Antialiased disc / ring coverage, one pixel coordinate in, one lit/alpha beat out.
// The pipeline has 3 front stages, 22 square root cells and 1 shading stage.
// Throughput: one beat per cycle; the whole chain advances whenever the output
// register is empty or being taken, and in_tready is that same advance condition.
// Reset (rst_n, synchronous, active low) empties the chain and sets the registers to
// center 0, radius one pixel, thickness one pixel, filled disc mode.
module antialiased_disc_ring_coverage #(
  parameter int IMAGE_SIZE = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: pixel_x [11:0], pixel_y [23:12]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,
  // out_tdata: lit [0], alpha [8:1], zero [15:9]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,
  input  logic                          cfg_we,
  input  logic [adc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [adc_pkg::RegW-1:0]      cfg_wdata
);
  import adc_pkg::*;

  localparam int NCells = RootW;

  logic [RegW-1:0] center_x_r, center_y_r, radius_r, thickness_r;
  logic            ring_mode_r;
  logic            adv, in_oob, lit;
  logic [7:0]      alpha;
  logic [PixW-1:0] px, py;
  adc_cell_t       chain [NCells+1];

  // Configuration registers; the user must see that they are only rewritten while the
  // chain is empty, so every stage may read them directly. The block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_r    <= RegW'(256);
      thickness_r <= RegW'(256);
      ring_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:  center_x_r  <= cfg_wdata;
        CFG_CENTER_Y:  center_y_r  <= cfg_wdata;
        CFG_RADIUS:    radius_r    <= cfg_wdata;
        CFG_THICKNESS: thickness_r <= cfg_wdata;
        CFG_RING_MODE: ring_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Global advance: the chain moves as one whenever the output beat can leave.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign px     = in_tdata[PixW-1:0];
  assign py     = in_tdata[2*PixW-1:PixW];
  // Coordinates beyond the image shade as black with no coverage.
  assign in_oob = (32'(px) >= 32'(IMAGE_SIZE)) || (32'(py) >= 32'(IMAGE_SIZE));

  // Front end: offsets from the center, squares and their sum.
  adc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .in_oob   (in_oob),
    .pixel_x  (px),
    .pixel_y  (py),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .cell_o   (chain[0])
  );

  // Row of square root cells, each producing one bit of the distance.
  for (genvar g = 0; g < NCells; g++) begin : g_cell
    adc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // Bands and body compare against the distance, then the output register.
  adc_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cell_i    (chain[NCells]),
    .radius    (radius_r),
    .thickness (thickness_r),
    .ring_mode (ring_mode_r),
    .valid_o   (out_tvalid),
    .lit_o     (lit),
    .alpha_o   (alpha)
  );

  assign out_tdata = {7'd0, alpha, lit};

endmodule

@@ sv/adc_checker.sv @@
module adc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("alpha set on an unlit pixel");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("padding bits not zero");

endmodule

bind antialiased_disc_ring_coverage adc_checker u_adc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
